// File: design/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants for the streaming box downscaler: field widths,
// configuration register indexes and the packed pixel and result types.
// ----------------------------------------------------------------------------
package sbd_pkg;

    // Configuration register widths and indexes
    localparam int SRC_W_BITS  = 13;
    localparam int TGT_W_BITS  = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE   = 2'd3;

    // Register reset values
    localparam logic [SRC_W_BITS-1:0] SOURCE_WIDTH_RST  = 13'd640;
    localparam logic [SRC_W_BITS-1:0] SOURCE_HEIGHT_RST = 13'd480;
    localparam logic [TGT_W_BITS-1:0] TARGET_WIDTH_RST  = 12'd320;
    localparam logic                  COLOUR_MODE_RST   = 1'b1;

    localparam logic [SRC_W_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

    // Accumulator widths and saturation limits
    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 24;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int COMPONENTS_DEF = 3;

    typedef struct packed {
        logic [7:0] in_c0;
        logic [7:0] in_c1;
        logic [7:0] in_c2;
    } in_t;

    typedef struct packed {
        logic [7:0]            out_c0;
        logic [7:0]            out_c1;
        logic [7:0]            out_c2;
        logic [TGT_W_BITS-1:0] out_column;
        logic                  row_end;
    } out_t;

endpackage

// File: design/sbd_div.sv
// ----------------------------------------------------------------------------
// sbd_div
// Restoring divider, one quotient bit per cycle. Start loads the operands;
// busy stays high until quotient and remainder are final.
// ----------------------------------------------------------------------------
module sbd_div #(
    parameter int NW = 32,
    parameter int DW = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    // Shift one dividend bit into the partial remainder and try to subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DW'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with exhausted count");
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && cnt_reg == CW'(NW)))
        else $error("divider start did not load");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == CW'(1)) |=> !busy_reg)
        else $error("divider ran past its last step");
`endif

endmodule

// File: design/streaming_box_downscaler_top.sv
// ----------------------------------------------------------------------------
// streaming_box_downscaler_top
// Box-filter downscaler: averages source pixels per output column and row group.
// ----------------------------------------------------------------------------
// One pixel transaction at a time. A pixel is accepted, read from memory, and
// then the column totals and count get a read-modify-write. A pixel that
// closes an output pixel then waits for the three 32-step average dividers to
// finish and loads the output register, which waits for as long as the
// previous output transaction is still held by out_ready. The first pixel
// after a register write first rebuilds the column and row scaling remainders
// with the same dividers: it forms the products, starts the dividers and waits
// for them to divide. Totals and counts live in two single-port synchronous
// memories of MAX_WIDTH rows; no clearing pass.
// ----------------------------------------------------------------------------
module streaming_box_downscaler_top #(
    parameter int MAX_WIDTH  = sbd_pkg::MAX_WIDTH_DEF,
    parameter int COMPONENTS = sbd_pkg::COMPONENTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  sbd_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output sbd_pkg::out_t                    out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sbd_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int MW = COMPONENTS * TOTAL_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SMUL   = 3'd1;
    localparam logic [2:0] ST_SSTART = 3'd2;
    localparam logic [2:0] ST_SDIV   = 3'd3;
    localparam logic [2:0] ST_RD     = 3'd4;
    localparam logic [2:0] ST_MOD    = 3'd5;
    localparam logic [2:0] ST_ADIV   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // Configuration registers
    logic [SRC_W_BITS-1:0] sw_reg, sh_reg;
    logic [TGT_W_BITS-1:0] tw_reg;
    logic                  mode_reg;
    logic                  dirty_reg;

    // Control state
    logic [2:0]            state_reg, state_next;
    logic [SRC_W_BITS-1:0] col_pos_reg, col_pos_next;
    logic [SRC_W_BITS-1:0] col_rem_reg, col_rem_next;
    logic [TGT_W_BITS-1:0] col_idx_reg, col_idx_next;
    logic [SRC_W_BITS-1:0] row_pos_reg, row_pos_next;
    logic [SRC_W_BITS-1:0] row_rem_reg, row_rem_next;
    logic [TGT_W_BITS-1:0] row_idx_reg, row_idx_next;
    logic [TGT_W_BITS-1:0] last_em_reg, last_em_next;
    logic                  fresh_reg, fresh_next;
    logic                  synced;
    logic                  out_valid_reg;

    // Payload registers
    in_t                   pix_reg;
    logic [24:0]           prod_c_reg, prod_r_reg;
    logic [COUNT_W-1:0]    num_reg;
    logic                  row_end_reg;
    logic [TGT_W_BITS-1:0] col_out_reg;
    out_t                  out_data_reg;

    // Memories
    logic [MW-1:0]         tot_mem [MAX_WIDTH];
    logic [COUNT_W-1:0]    cnt_mem [MAX_WIDTH];
    logic [MW-1:0]         tot_rd_reg;
    logic [COUNT_W-1:0]    cnt_rd_reg;
    logic [MW-1:0]         tot_wr;
    logic [COUNT_W-1:0]    cnt_wr;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;

    // Per-item combinational terms
    logic                  in_fire, usable, x_last, first, last, emit, overwrite;
    logic [SRC_W_BITS:0]   col_step, row_step;
    logic [7:0]            pix_c [3];
    logic [TOTAL_W-1:0]    tot_rd [3];
    logic [TOTAL_W-1:0]    tot_new [3];
    logic [COUNT_W-1:0]    cnt_new;
    logic                  lane_on [3];

    // Divider lanes
    logic                  div_start;
    logic [TOTAL_W-1:0]    div_num [3];
    logic [COUNT_W-1:0]    div_den [3];
    logic                  div_busy [3];
    logic [TOTAL_W-1:0]    div_quo [3];
    logic [COUNT_W-1:0]    div_rem [3];
    logic [7:0]            avg [3];

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign usable = (sw_reg >= 13'd2) && (32'(sw_reg) <= MAX_WIDTH) &&
                    (sh_reg >= 13'd1) && (sh_reg <= HEIGHT_LIMIT) &&
                    (tw_reg != '0) && ({1'b0, tw_reg} < sw_reg);

    // Write configuration registers; mark scaling remainders stale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg    <= SOURCE_WIDTH_RST;
            sh_reg    <= SOURCE_HEIGHT_RST;
            tw_reg    <= TARGET_WIDTH_RST;
            mode_reg  <= COLOUR_MODE_RST;
            dirty_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SOURCE_WIDTH:  sw_reg   <= cfg_data;
                    CFG_SOURCE_HEIGHT: sh_reg   <= cfg_data;
                    CFG_TARGET_WIDTH:  tw_reg   <= cfg_data[TGT_W_BITS-1:0];
                    CFG_COLOUR_MODE:   mode_reg <= cfg_data[0];
                    default:           ;
                endcase
                dirty_reg <= 1'b1;
            end
            else if (synced)
                dirty_reg <= 1'b0;
        end
    end

    // Decode the current pixel against the scaling remainders
    assign x_last    = (col_pos_reg == sw_reg - 13'd1);
    assign first     = (col_pos_reg == '0) || (col_rem_reg < {1'b0, tw_reg});
    assign col_step  = {1'b0, col_rem_reg} + {2'b0, tw_reg};
    assign row_step  = {1'b0, row_rem_reg} + {2'b0, tw_reg};
    assign last      = x_last || (col_step >= {1'b0, sw_reg});
    assign emit      = (row_idx_reg > last_em_reg);
    assign overwrite = fresh_reg && first;
    assign pix_c[0]  = pix_reg.in_c0;
    assign pix_c[1]  = pix_reg.in_c1;
    assign pix_c[2]  = pix_reg.in_c2;
    assign mem_addr  = AW'(col_idx_reg);

    // Accumulate totals and count, saturating; restart them on the first pixel of a fresh group
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lane_on[c] = (c == 0) || (mode_reg && (c < COMPONENTS));
            tot_rd[c]  = (c < COMPONENTS) ? tot_rd_reg[(c % COMPONENTS) * TOTAL_W +: TOTAL_W]
                                          : '0;
            if (!lane_on[c])
                tot_new[c] = tot_rd[c];
            else if (overwrite)
                tot_new[c] = TOTAL_W'(pix_c[c]);
            else if (tot_rd[c] > TOTAL_MAX - TOTAL_W'(pix_c[c]))
                tot_new[c] = TOTAL_MAX;
            else
                tot_new[c] = tot_rd[c] + TOTAL_W'(pix_c[c]);
        end
        tot_wr = tot_rd_reg;
        for (int c = 0; c < COMPONENTS; c++)
            tot_wr[c * TOTAL_W +: TOTAL_W] = tot_new[c];
        if (overwrite)
            cnt_new = COUNT_W'(1);
        else if (cnt_rd_reg != COUNT_MAX)
            cnt_new = cnt_rd_reg + 1'b1;
        else
            cnt_new = cnt_rd_reg;
        cnt_wr = cnt_new;
    end

    assign mem_we = (state_reg == ST_MOD);

    // Read at the output column, write back the updated row
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tot_mem[mem_addr] <= tot_wr;
            cnt_mem[mem_addr] <= cnt_wr;
        end
        if (state_reg == ST_RD)
        begin
            tot_rd_reg <= tot_mem[mem_addr];
            cnt_rd_reg <= cnt_mem[mem_addr];
        end
    end

    // Feed dividers: scaling remainders on resync, averages on emit
    assign div_start = (state_reg == ST_SSTART) || (state_reg == ST_MOD && emit && last);
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            div_num[c] = tot_new[c];
            div_den[c] = cnt_new;
        end
        if (state_reg == ST_SSTART)
        begin
            div_num[0] = TOTAL_W'(prod_c_reg);
            div_den[0] = COUNT_W'(sw_reg);
            div_num[1] = TOTAL_W'(prod_r_reg);
            div_den[1] = COUNT_W'(sw_reg);
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        sbd_div #(
            .NW (TOTAL_W),
            .DW (COUNT_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (div_start),
            .dividend  (div_num[g]),
            .divisor   (div_den[g]),
            .busy      (div_busy[g]),
            .quotient  (div_quo[g]),
            .remainder (div_rem[g])
        );
    end

    // Mask averages of inactive lanes and empty counts
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            avg[c] = (lane_on[c] && num_reg != '0) ? div_quo[c][7:0] : 8'd0;
    end

    assign synced = (state_reg == ST_SDIV) && !div_busy[0];

    // Sequence one pixel: normalize, resync, read, modify, emit
    always_comb
    begin
        state_next   = state_reg;
        col_pos_next = col_pos_reg;
        col_rem_next = col_rem_reg;
        col_idx_next = col_idx_reg;
        row_pos_next = row_pos_reg;
        row_rem_next = row_rem_reg;
        row_idx_next = row_idx_reg;
        last_em_next = last_em_reg;
        fresh_next   = fresh_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && usable)
                begin
                    if (col_pos_reg >= sw_reg)
                    begin
                        col_pos_next = '0;
                        col_rem_next = '0;
                        col_idx_next = '0;
                    end
                    if (row_pos_reg >= sh_reg)
                    begin
                        row_pos_next = '0;
                        row_rem_next = '0;
                        row_idx_next = '0;
                        last_em_next = '0;
                        fresh_next   = 1'b1;
                    end
                    state_next = dirty_reg ? ST_SMUL : ST_RD;
                end
            end
            ST_SMUL:   state_next = ST_SSTART;
            ST_SSTART: state_next = ST_SDIV;
            ST_SDIV:
            begin
                if (!div_busy[0])
                begin
                    col_idx_next = div_quo[0][TGT_W_BITS-1:0];
                    col_rem_next = div_rem[0][SRC_W_BITS-1:0];
                    row_idx_next = div_quo[1][TGT_W_BITS-1:0];
                    row_rem_next = div_rem[1][SRC_W_BITS-1:0];
                    state_next   = ST_RD;
                end
            end
            ST_RD:     state_next = ST_MOD;
            ST_MOD:
            begin
                state_next = (emit && last) ? ST_ADIV : ST_IDLE;
                if (x_last)
                begin
                    col_pos_next = '0;
                    col_rem_next = '0;
                    col_idx_next = '0;
                    if (emit)
                    begin
                        last_em_next = row_idx_reg;
                        fresh_next   = 1'b1;
                    end
                    else
                        fresh_next = 1'b0;
                    if (row_pos_reg + 13'd1 >= sh_reg)
                    begin
                        row_pos_next = '0;
                        row_rem_next = '0;
                        row_idx_next = '0;
                        last_em_next = '0;
                        fresh_next   = 1'b1;
                    end
                    else
                    begin
                        row_pos_next = row_pos_reg + 13'd1;
                        if (row_step >= {1'b0, sw_reg})
                        begin
                            row_rem_next = SRC_W_BITS'(row_step - {1'b0, sw_reg});
                            row_idx_next = row_idx_reg + 1'b1;
                        end
                        else
                            row_rem_next = row_step[SRC_W_BITS-1:0];
                    end
                end
                else
                begin
                    col_pos_next = col_pos_reg + 13'd1;
                    if (col_step >= {1'b0, sw_reg})
                    begin
                        col_rem_next = SRC_W_BITS'(col_step - {1'b0, sw_reg});
                        col_idx_next = col_idx_reg + 1'b1;
                    end
                    else
                        col_rem_next = col_step[SRC_W_BITS-1:0];
                end
            end
            ST_ADIV:
            begin
                if (!div_busy[0])
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_pos_reg   <= '0;
            col_rem_reg   <= '0;
            col_idx_reg   <= '0;
            row_pos_reg   <= '0;
            row_rem_reg   <= '0;
            row_idx_reg   <= '0;
            last_em_reg   <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_pos_reg <= col_pos_next;
            col_rem_reg <= col_rem_next;
            col_idx_reg <= col_idx_next;
            row_pos_reg <= row_pos_next;
            row_rem_reg <= row_rem_next;
            row_idx_reg <= row_idx_next;
            last_em_reg <= last_em_next;
            fresh_reg   <= fresh_next;
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold pixel, products, emit context and the output transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
            pix_reg <= in_data;
        if (state_reg == ST_SMUL)
        begin
            prod_c_reg <= 25'(col_pos_reg[TGT_W_BITS-1:0] * tw_reg);
            prod_r_reg <= 25'(row_pos_reg[TGT_W_BITS-1:0] * tw_reg);
        end
        if (state_reg == ST_MOD)
        begin
            num_reg     <= cnt_new;
            row_end_reg <= x_last;
            col_out_reg <= col_idx_reg;
        end
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            out_data_reg.out_c0     <= avg[0];
            out_data_reg.out_c1     <= avg[1];
            out_data_reg.out_c2     <= avg[2];
            out_data_reg.out_column <= col_out_reg;
            out_data_reg.row_end    <= row_end_reg;
        end
    end

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output loaded outside output step");
    a_emit_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && emit && last) |=> (state_reg == ST_ADIV && div_busy[0]))
        else $error("emit did not start averaging");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD && !dirty_reg) |-> (col_rem_reg < sw_reg && row_rem_reg < sw_reg))
        else $error("scaling remainder out of range");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy[0])
        else $error("divider restarted while busy");
`endif

endmodule
